[rtl/sdh_pkg.sv]
// Shared types and constants for the SD card SPI host sequencer.
package sdh_pkg;

  localparam int unsigned BLOCK_BYTES   = 512;
  localparam int unsigned R1_POLL_LIMIT = 10;
  localparam int unsigned CMD0_TRIES    = 10;
  localparam int unsigned WAKE_BYTES    = 10;

  typedef enum logic [2:0] {
    ACT_INIT  = 3'd0,
    ACT_READ  = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_BYTE  = 3'd3,
    ACT_TICK  = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAKE, PH_CMD, PH_R7, PH_OCR, PH_BUSY_BEFORE, PH_TOKEN,
    PH_RDATA, PH_RCRC, PH_WGAP, PH_WDATA, PH_WCRC, PH_WRESP,
    PH_BUSY_AFTER, PH_DESEL
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_INIT  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  // Done status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_NOT_INIT    = 4'd1;
  localparam logic [3:0] ST_NO_IDLE     = 4'd2;
  localparam logic [3:0] ST_BAD_IF      = 4'd3;
  localparam logic [3:0] ST_INIT_TMO    = 4'd4;
  localparam logic [3:0] ST_OCR_FAIL    = 4'd5;
  localparam logic [3:0] ST_BLKLEN_FAIL = 4'd6;
  localparam logic [3:0] ST_CMD_REJ     = 4'd7;
  localparam logic [3:0] ST_TOKEN_ERR   = 4'd8;
  localparam logic [3:0] ST_BUSY_BEFORE = 4'd9;
  localparam logic [3:0] ST_WR_REJ      = 4'd10;
  localparam logic [3:0] ST_BUSY_AFTER  = 4'd11;

  // Configuration register indexes
  localparam logic [1:0] REG_INIT_TMO = 2'd0;
  localparam logic [1:0] REG_READ_TMO = 2'd1;
  localparam logic [1:0] REG_BUSY_TMO = 2'd2;

  typedef struct packed {
    phase_t      phase;
    logic [9:0]  byte_count;
    logic [3:0]  try_count;
    logic [15:0] elapsed_ms;
    logic [1:0]  kind_of_card;
    logic        block_addressing;
    logic        second_version;
    op_t         operation;
    logic [31:0] target_address;
    logic [47:0] command_frame;
    logic [7:0]  reply_capture;
  } state_t;

  typedef struct packed {
    logic [15:0] init_tmo;
    logic [15:0] read_tmo;
    logic [15:0] busy_tmo;
  } cfg_t;

  // Result fields, lowest bit first in the packed order below reversed
  typedef struct packed {
    logic [1:0] card_kind;
    logic [3:0] status;
    logic       done_res;
    logic       write_taken;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       slow_clock;
    logic       select_low;
    logic [7:0] tx_byte;
    logic       exchange;
  } result_t;

endpackage

[rtl/sdh_step.sv]
// Next-state and result logic for one input item of the SD SPI host sequencer.
module sdh_step (
  input  sdh_pkg::state_t  st,
  input  sdh_pkg::cfg_t    cfg,
  input  logic [2:0]       action,
  input  logic [31:0]      block_number,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       write_byte,
  output sdh_pkg::state_t  st_next,
  output sdh_pkg::result_t res,
  output logic             produced
);
  import sdh_pkg::*;

  logic [9:0]  bc;
  logic        exch;
  logic [7:0]  tx;
  logic        cmd_go;
  logic [5:0]  cidx;
  logic [31:0] carg;
  logic [7:0]  ccrc;
  logic        desel;
  logic [3:0]  dst;
  logic        fin;
  logic [3:0]  fst;
  logic [7:0]  r1;
  logic        have_r1;
  logic [3:0]  tries;
  logic [31:0] addr;

  always_comb begin
    st_next = st;
    res     = '0;
    produced = 1'b0;
    exch = 1'b0;
    tx   = 8'hFF;
    cmd_go = 1'b0;
    cidx = '0;
    carg = '0;
    ccrc = '0;
    desel = 1'b0;
    dst = ST_OK;
    fin = 1'b0;
    fst = ST_OK;
    r1 = 8'hFF;
    have_r1 = 1'b0;
    bc = st.byte_count + 10'd1;
    tries = st.try_count + 4'd1;
    addr = st.block_addressing ? block_number : {block_number[22:0], 9'd0};

    // Dispatch on action and phase
    if (action == ACT_TICK) begin
      if (st.elapsed_ms != 16'hFFFF) st_next.elapsed_ms = st.elapsed_ms + 16'd1;
    end else if (action == ACT_INIT || action == ACT_READ || action == ACT_WRITE) begin
      if (st.phase == PH_IDLE) begin
        produced = 1'b1;
        if (action == ACT_INIT) begin
          st_next.kind_of_card = 2'd0;
          st_next.block_addressing = 1'b0;
          st_next.second_version = 1'b0;
          st_next.operation = OP_INIT;
          st_next.phase = PH_WAKE;
          st_next.byte_count = '0;
          exch = 1'b1;
        end else if (st.kind_of_card == 2'd0) begin
          st_next.operation = OP_NONE;
          fin = 1'b1;
          fst = ST_NOT_INIT;
        end else begin
          st_next.operation = (action == ACT_READ) ? OP_READ : OP_WRITE;
          st_next.target_address = addr;
          st_next.elapsed_ms = '0;
          if (cfg.busy_tmo == 16'd0) begin
            desel = 1'b1; dst = ST_BUSY_BEFORE;
          end else begin
            st_next.phase = PH_BUSY_BEFORE; st_next.byte_count = '0; exch = 1'b1;
          end
        end
      end
    end else if (action == ACT_BYTE && st.phase != PH_IDLE) begin
      produced = 1'b1;
      unique case (st.phase)
        PH_DESEL: begin
          fin = 1'b1;
          fst = st.reply_capture[3:0];
        end
        PH_WAKE: begin
          st_next.byte_count = bc;
          if (bc < 10'(WAKE_BYTES)) exch = 1'b1;
          else begin
            st_next.try_count = '0;
            cmd_go = 1'b1; cidx = 6'd0; ccrc = 8'h95;
          end
        end
        PH_CMD: begin
          st_next.byte_count = bc;
          if (bc <= 10'd6) begin
            exch = 1'b1;
            unique case (bc[2:0])
              3'd1:    tx = st.command_frame[47:40];
              3'd2:    tx = st.command_frame[39:32];
              3'd3:    tx = st.command_frame[31:24];
              3'd4:    tx = st.command_frame[23:16];
              3'd5:    tx = st.command_frame[15:8];
              default: tx = st.command_frame[7:0];
            endcase
          end else if (bc == 10'd7) exch = 1'b1;
          else if (!rx_byte[7]) begin
            have_r1 = 1'b1; r1 = rx_byte;
          end else if (bc >= 10'(R1_POLL_LIMIT + 7)) begin
            have_r1 = 1'b1; r1 = 8'hFF;
          end else exch = 1'b1;
        end
        PH_R7: begin
          st_next.byte_count = bc;
          if (bc == 10'd3) st_next.reply_capture = {7'd0, rx_byte == 8'h01};
          if (bc < 10'd4) exch = 1'b1;
          else if (st_next.reply_capture == 8'd1 && rx_byte == 8'hAA) begin
            st_next.second_version = 1'b1;
            st_next.elapsed_ms = '0;
            cmd_go = 1'b1; cidx = 6'd55; ccrc = 8'h01;
          end else begin
            desel = 1'b1; dst = ST_BAD_IF;
          end
        end
        PH_OCR: begin
          st_next.byte_count = bc;
          if (bc == 10'd1) st_next.reply_capture = rx_byte;
          if (bc < 10'd4) exch = 1'b1;
          else begin
            st_next.block_addressing = st_next.reply_capture[6];
            if (!st_next.reply_capture[6]) begin
              cmd_go = 1'b1; cidx = 6'd16; carg = 32'(BLOCK_BYTES); ccrc = 8'h01;
            end else begin
              desel = 1'b1; dst = ST_OK;
            end
          end
        end
        PH_BUSY_BEFORE: begin
          if (rx_byte == 8'hFF) begin
            cmd_go = 1'b1;
            cidx = (st.operation == OP_READ) ? 6'd17 : 6'd24;
            carg = st.target_address; ccrc = 8'h01;
          end else if (st.elapsed_ms >= cfg.busy_tmo) begin
            desel = 1'b1; dst = ST_BUSY_BEFORE;
          end else exch = 1'b1;
        end
        PH_TOKEN: begin
          if (rx_byte != 8'hFF) begin
            if (rx_byte == 8'hFE) begin
              st_next.phase = PH_RDATA; st_next.byte_count = '0; exch = 1'b1;
            end else begin
              desel = 1'b1; dst = ST_TOKEN_ERR;
            end
          end else if (st.elapsed_ms >= cfg.read_tmo) begin
            desel = 1'b1; dst = ST_TOKEN_ERR;
          end else exch = 1'b1;
        end
        PH_RDATA: begin
          res.read_valid = 1'b1;
          res.read_byte = rx_byte;
          st_next.byte_count = bc;
          if (bc >= 10'(BLOCK_BYTES)) begin
            st_next.phase = PH_RCRC; st_next.byte_count = '0;
          end
          exch = 1'b1;
        end
        PH_RCRC: begin
          st_next.byte_count = bc;
          if (bc < 10'd2) exch = 1'b1;
          else begin
            desel = 1'b1; dst = ST_OK;
          end
        end
        PH_WGAP: begin
          st_next.phase = PH_WDATA; st_next.byte_count = '0;
          exch = 1'b1; tx = 8'hFE;
        end
        PH_WDATA: begin
          exch = 1'b1;
          if (st.byte_count < 10'(BLOCK_BYTES)) begin
            st_next.byte_count = bc;
            res.write_taken = 1'b1;
            tx = write_byte;
          end else begin
            st_next.phase = PH_WCRC; st_next.byte_count = 10'd1;
          end
        end
        PH_WCRC: begin
          if (st.byte_count < 10'd2) st_next.byte_count = bc;
          else st_next.phase = PH_WRESP;
          exch = 1'b1;
        end
        PH_WRESP: begin
          if (rx_byte[4:0] != 5'h05) begin
            desel = 1'b1; dst = ST_WR_REJ;
          end else begin
            st_next.elapsed_ms = '0;
            if (cfg.busy_tmo == 16'd0) begin
              desel = 1'b1; dst = ST_BUSY_AFTER;
            end else begin
              st_next.phase = PH_BUSY_AFTER; st_next.byte_count = '0; exch = 1'b1;
            end
          end
        end
        PH_BUSY_AFTER: begin
          if (rx_byte == 8'hFF) begin
            desel = 1'b1; dst = ST_OK;
          end else if (st.elapsed_ms >= cfg.busy_tmo) begin
            desel = 1'b1; dst = ST_BUSY_AFTER;
          end else exch = 1'b1;
        end
        default: ;
      endcase
    end

    // Command reply handling
    if (have_r1) begin
      unique case (st.command_frame[45:40])
        6'd0: begin
          if (r1 == 8'h01) begin
            cmd_go = 1'b1; cidx = 6'd8; carg = 32'h0000_01AA; ccrc = 8'h87;
          end else begin
            st_next.try_count = tries;
            if (tries >= 4'(CMD0_TRIES)) begin
              desel = 1'b1; dst = ST_NO_IDLE;
            end else begin
              cmd_go = 1'b1; cidx = 6'd0; ccrc = 8'h95;
            end
          end
        end
        6'd8: begin
          if (r1 == 8'h01) begin
            st_next.phase = PH_R7; st_next.byte_count = '0;
            st_next.reply_capture = '0; exch = 1'b1;
          end else if (r1[2]) begin
            st_next.second_version = 1'b0;
            st_next.elapsed_ms = '0;
            cmd_go = 1'b1; cidx = 6'd55; ccrc = 8'h01;
          end else begin
            desel = 1'b1; dst = ST_BAD_IF;
          end
        end
        6'd55, 6'd41: begin
          if (st.command_frame[45:40] == 6'd55 && r1 <= 8'h01) begin
            cmd_go = 1'b1; cidx = 6'd41; ccrc = 8'h01;
            carg = st.second_version ? 32'h4000_0000 : 32'd0;
          end else if (r1 == 8'd0) begin
            if (st.second_version) begin
              cmd_go = 1'b1; cidx = 6'd58; ccrc = 8'h01;
            end else if (!st.block_addressing) begin
              cmd_go = 1'b1; cidx = 6'd16; carg = 32'(BLOCK_BYTES); ccrc = 8'h01;
            end else begin
              desel = 1'b1; dst = ST_OK;
            end
          end else if (st.elapsed_ms >= cfg.init_tmo) begin
            desel = 1'b1; dst = ST_INIT_TMO;
          end else begin
            cmd_go = 1'b1; cidx = 6'd55; ccrc = 8'h01;
          end
        end
        6'd58: begin
          if (r1 != 8'd0) begin
            desel = 1'b1; dst = ST_OCR_FAIL;
          end else begin
            st_next.phase = PH_OCR; st_next.byte_count = '0; exch = 1'b1;
          end
        end
        6'd16: begin
          desel = 1'b1; dst = (r1 != 8'd0) ? ST_BLKLEN_FAIL : ST_OK;
        end
        6'd17: begin
          if (r1 != 8'd0) begin
            desel = 1'b1; dst = ST_CMD_REJ;
          end else begin
            st_next.elapsed_ms = '0;
            if (cfg.read_tmo == 16'd0) begin
              desel = 1'b1; dst = ST_TOKEN_ERR;
            end else begin
              st_next.phase = PH_TOKEN; st_next.byte_count = '0; exch = 1'b1;
            end
          end
        end
        6'd24: begin
          if (r1 != 8'd0) begin
            desel = 1'b1; dst = ST_CMD_REJ;
          end else begin
            st_next.phase = PH_WGAP; exch = 1'b1;
          end
        end
        default: begin
          desel = 1'b1; dst = ST_CMD_REJ;
        end
      endcase
    end

    // Launch a command frame
    if (cmd_go) begin
      st_next.command_frame = {2'b01, cidx, carg, ccrc};
      st_next.phase = PH_CMD;
      st_next.byte_count = '0;
      exch = 1'b1;
      tx = 8'hFF;
    end

    // Trailing deselected byte
    if (desel) begin
      st_next.reply_capture = {4'd0, dst};
      st_next.phase = PH_DESEL;
      exch = 1'b1;
      tx = 8'hFF;
    end

    // Finish the operation
    if (fin) begin
      if (st_next.operation == OP_INIT && fst == ST_OK)
        st_next.kind_of_card = st.second_version ?
                               (st.block_addressing ? 2'd3 : 2'd2) : 2'd1;
      st_next.phase = PH_IDLE;
      st_next.operation = OP_NONE;
      res.done_res = 1'b1;
      res.status = fst;
    end

    if (exch) begin
      res.exchange = 1'b1;
      res.tx_byte = tx;
      res.select_low = !(st_next.phase == PH_WAKE || st_next.phase == PH_DESEL);
    end
    res.slow_clock = (st_next.kind_of_card == 2'd0);
    res.card_kind = st_next.kind_of_card;
  end

endmodule

[rtl/sd_card_spi_host_engine_core.sv]
// Top level of the SD card SPI host sequencer: state, config and result registers.
//
// Usage:
//   Input stream (s_*): one request per item. s_tuser carries the action
//   (start init, start read, start write, byte received, millisecond tick);
//   s_tdata carries block_number, rx_byte and write_byte.
//   Output stream (m_*): at most one result per request: the next byte to
//   exchange with chip select and clock choice, a read payload byte, the
//   write_taken flag, or done with a status and the card kind.
//   Config channel (cfg_*): writes the three millisecond timeouts; always ready.
//   The user must write it only while the sequencer is idle; the core does not enforce it.
// Timing:
//   A request is processed in the cycle it is accepted and its result, if any,
//   is in the output register on the next cycle. One request per cycle is
//   sustained while m_tready keeps up; the single state register update sets the rate.
// Reset:
//   rst clears the sequencer to idle with no card known and loads the
//   default timeouts (1000, 200, 500 ms).
// Stall:
//   While a result waits and m_tready is low, s_tready is low; it rises in
//   the same cycle the waiting result is taken.
module sd_card_spi_host_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // block_number[31:0], rx_byte[39:32], write_byte[47:40]
  input  logic [2:0]  s_tuser,   // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // exchange, tx_byte, select_low, slow_clock, read_valid,
                                 // read_byte, write_taken, done_res, status, card_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sdh_pkg::*;

  state_t  st;
  state_t  st_next;
  cfg_t    cfg;
  result_t res;
  result_t res_q;
  logic    produced;
  logic    s_fire;

  assign s_tready  = !m_tvalid || m_tready;
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {4'd0, res_q};

  sdh_step u_step (
    .st           (st),
    .cfg          (cfg),
    .action       (s_tuser),
    .block_number (s_tdata[31:0]),
    .rx_byte      (s_tdata[39:32]),
    .write_byte   (s_tdata[47:40]),
    .st_next      (st_next),
    .res          (res),
    .produced     (produced)
  );

  // Sequencer state; all-zero is idle, no operation, no card
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s_fire) begin
      st <= st_next;
    end
  end

  // Timeout registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_tmo <= 16'd1000;
      cfg.read_tmo <= 16'd200;
      cfg.busy_tmo <= 16'd500;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INIT_TMO: cfg.init_tmo <= cfg_data;
        REG_READ_TMO: cfg.read_tmo <= cfg_data;
        REG_BUSY_TMO: cfg.busy_tmo <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire && produced) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && produced) res_q <= res;
  end

endmodule

[tb/sdh_checker.sv]
// Response checker for the SD SPI host sequencer: predicts each result and compares it.
`timescale 1ns / 100ps

module sdh_resp_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [47:0]      s_tdata,
  input  logic [2:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [31:0]      m_tdata,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output int               fail_count,
  output int               pending,
  output sdh_pkg::phase_t  pred_phase,
  output logic [5:0]       pred_cmd,
  output logic [9:0]       pred_count,
  output logic [1:0]       pred_kind
);
  import sdh_pkg::*;

  // Shadow sequencer state
  phase_t      ph;
  logic [9:0]  bcnt;
  logic [3:0]  tries;
  logic [15:0] ms;
  logic [1:0]  kind;
  logic        blk_addr;
  logic        v2;
  op_t         op;
  logic [31:0] addr;
  logic [47:0] frame;
  logic [7:0]  cap;
  logic [15:0] tmo_init, tmo_read, tmo_busy;

  result_t nx;
  result_t want_q[$];

  assign pred_phase = ph;
  assign pred_cmd   = frame[45:40];
  assign pred_count = bcnt;
  assign pred_kind  = kind;

  function automatic void emit(input logic [7:0] tx);
    nx.exchange   = 1'b1;
    nx.tx_byte    = tx;
    nx.select_low = !(ph == PH_WAKE || ph == PH_DESEL);
  endfunction

  function automatic void desel(input logic [3:0] st);
    cap = {4'd0, st};
    ph  = PH_DESEL;
    emit(8'hFF);
  endfunction

  function automatic void issue(input logic [5:0] idx, input logic [31:0] arg,
                                input logic [7:0] crc);
    frame = {2'b01, idx, arg, crc};
    ph    = PH_CMD;
    bcnt  = '0;
    emit(8'hFF);
  endfunction

  function automatic void acmd_loop();
    ms = '0;
    issue(6'd55, 32'd0, 8'h01);
  endfunction

  // CMD16 on byte-addressed cards, else init is complete
  function automatic void blocklen_or_finish();
    if (!blk_addr) issue(6'd16, 32'(BLOCK_BYTES), 8'h01);
    else desel(ST_OK);
  endfunction

  function automatic void acmd_reply(input logic [7:0] r1);
    if (r1 == 8'h00) begin
      if (v2) issue(6'd58, 32'd0, 8'h01);
      else blocklen_or_finish();
    end else if (ms >= tmo_init) begin
      desel(ST_INIT_TMO);
    end else begin
      issue(6'd55, 32'd0, 8'h01);
    end
  endfunction

  function automatic void start_wait(input phase_t nph, input logic [15:0] lim,
                                     input logic [3:0] st);
    ms = '0;
    if (lim == 16'd0) begin
      desel(st);
    end else begin
      ph   = nph;
      bcnt = '0;
      emit(8'hFF);
    end
  endfunction

  // R1 handling per command index
  function automatic void r1_done(input logic [7:0] r1);
    case (frame[45:40])
      6'd0: begin
        if (r1 == 8'h01) begin
          issue(6'd8, 32'h0000_01AA, 8'h87);
        end else begin
          tries = tries + 4'd1;
          if (tries >= CMD0_TRIES) desel(ST_NO_IDLE);
          else issue(6'd0, 32'd0, 8'h95);
        end
      end
      6'd8: begin
        if (r1 == 8'h01) begin
          ph = PH_R7; bcnt = '0; cap = '0;
          emit(8'hFF);
        end else if (r1[2]) begin
          v2 = 1'b0;
          acmd_loop();
        end else begin
          desel(ST_BAD_IF);
        end
      end
      6'd55: begin
        if (r1 > 8'h01) acmd_reply(r1);
        else issue(6'd41, v2 ? 32'h4000_0000 : 32'd0, 8'h01);
      end
      6'd41: acmd_reply(r1);
      6'd58: begin
        if (r1 != 8'h00) begin
          desel(ST_OCR_FAIL);
        end else begin
          ph = PH_OCR; bcnt = '0;
          emit(8'hFF);
        end
      end
      6'd16: desel(r1 != 8'h00 ? ST_BLKLEN_FAIL : ST_OK);
      6'd17: begin
        if (r1 != 8'h00) desel(ST_CMD_REJ);
        else start_wait(PH_TOKEN, tmo_read, ST_TOKEN_ERR);
      end
      6'd24: begin
        if (r1 != 8'h00) begin
          desel(ST_CMD_REJ);
        end else begin
          ph = PH_WGAP;
          emit(8'hFF);
        end
      end
      default: desel(ST_CMD_REJ);
    endcase
  endfunction

  function automatic void card_byte(input logic [7:0] rx, input logic [7:0] wb);
    int bc;
    bc = int'(bcnt) + 1;
    case (ph)
      PH_WAKE: begin
        bcnt = bc[9:0];
        if (bc < WAKE_BYTES) begin
          emit(8'hFF);
        end else begin
          tries = '0;
          issue(6'd0, 32'd0, 8'h95);
        end
      end
      PH_CMD: begin
        bcnt = bc[9:0];
        if (bc <= 6) emit(8'(frame >> (40 - 8 * (bc - 1))));
        else if (bc == 7) emit(8'hFF);
        else if (!rx[7]) r1_done(rx);
        else if (bc - 7 >= R1_POLL_LIMIT) r1_done(8'hFF);
        else emit(8'hFF);
      end
      PH_R7: begin
        bcnt = bc[9:0];
        if (bc == 3) cap = (rx == 8'h01) ? 8'd1 : 8'd0;
        if (bc < 4) begin
          emit(8'hFF);
        end else if (cap == 8'd1 && rx == 8'hAA) begin
          v2 = 1'b1;
          acmd_loop();
        end else begin
          desel(ST_BAD_IF);
        end
      end
      PH_OCR: begin
        bcnt = bc[9:0];
        if (bc == 1) cap = rx;
        if (bc < 4) begin
          emit(8'hFF);
        end else begin
          blk_addr = cap[6];
          blocklen_or_finish();
        end
      end
      PH_BUSY_BEFORE: begin
        if (rx == 8'hFF) issue(op == OP_READ ? 6'd17 : 6'd24, addr, 8'h01);
        else if (ms >= tmo_busy) desel(ST_BUSY_BEFORE);
        else emit(8'hFF);
      end
      PH_TOKEN: begin
        if (rx != 8'hFF) begin
          if (rx == 8'hFE) begin
            ph = PH_RDATA; bcnt = '0;
            emit(8'hFF);
          end else begin
            desel(ST_TOKEN_ERR);
          end
        end else if (ms >= tmo_read) begin
          desel(ST_TOKEN_ERR);
        end else begin
          emit(8'hFF);
        end
      end
      PH_RDATA: begin
        nx.read_valid = 1'b1;
        nx.read_byte  = rx;
        bcnt = bc[9:0];
        if (bc >= BLOCK_BYTES) begin
          ph = PH_RCRC; bcnt = '0;
        end
        emit(8'hFF);
      end
      PH_RCRC: begin
        bcnt = bc[9:0];
        if (bc < 2) emit(8'hFF);
        else desel(ST_OK);
      end
      PH_WGAP: begin
        ph = PH_WDATA; bcnt = '0;
        emit(8'hFE);
      end
      PH_WDATA: begin
        if (bcnt < BLOCK_BYTES) begin
          bcnt = bc[9:0];
          nx.write_taken = 1'b1;
          emit(wb);
        end else begin
          ph = PH_WCRC; bcnt = 10'd1;
          emit(8'hFF);
        end
      end
      PH_WCRC: begin
        if (bcnt < 2) bcnt = bc[9:0];
        else ph = PH_WRESP;
        emit(8'hFF);
      end
      PH_WRESP: begin
        if (rx[4:0] != 5'h05) desel(ST_WR_REJ);
        else start_wait(PH_BUSY_AFTER, tmo_busy, ST_BUSY_AFTER);
      end
      PH_BUSY_AFTER: begin
        if (rx == 8'hFF) desel(ST_OK);
        else if (ms >= tmo_busy) desel(ST_BUSY_AFTER);
        else emit(8'hFF);
      end
      default: ;
    endcase
  endfunction

  function automatic void wrap_up(input logic [3:0] st);
    if (op == OP_INIT && st == ST_OK) kind = v2 ? (blk_addr ? 2'd3 : 2'd2) : 2'd1;
    ph = PH_IDLE;
    op = OP_NONE;
    nx.done_res = 1'b1;
    nx.status   = st;
  endfunction

  // One accepted request; pushes the expected result if it makes one
  function automatic void predict_step(input action_t a, input logic [31:0] blk,
                                       input logic [7:0] rx, input logic [7:0] wb);
    bit made;
    made = 1'b0;
    nx   = '0;
    case (a)
      ACT_TICK: if (ms != 16'hFFFF) ms = ms + 16'd1;
      ACT_INIT, ACT_READ, ACT_WRITE: begin
        if (ph == PH_IDLE) begin
          made = 1'b1;
          if (a == ACT_INIT) begin
            kind = '0; blk_addr = 1'b0; v2 = 1'b0;
            op = OP_INIT; ph = PH_WAKE; bcnt = '0;
            emit(8'hFF);
          end else if (kind == 2'd0) begin
            op = OP_NONE;
            wrap_up(ST_NOT_INIT);
          end else begin
            op   = (a == ACT_READ) ? OP_READ : OP_WRITE;
            addr = blk_addr ? blk : {blk[22:0], 9'd0};
            start_wait(PH_BUSY_BEFORE, tmo_busy, ST_BUSY_BEFORE);
          end
        end
      end
      ACT_BYTE: begin
        if (ph != PH_IDLE) begin
          made = 1'b1;
          if (ph == PH_DESEL) wrap_up(cap[3:0]);
          else card_byte(rx, wb);
        end
      end
      default: ;
    endcase
    if (made) begin
      nx.slow_clock = (kind == 2'd0);
      nx.card_kind  = kind;
      want_q.push_back(nx);
    end
  endfunction

  function automatic void cmp(input string fld, input logic [31:0] exp_v,
                              input logic [31:0] got);
    if (exp_v !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fld, exp_v, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t got, ref_r;
    if (rst) begin
      ph = PH_IDLE; bcnt = '0; tries = '0; ms = '0; kind = '0;
      blk_addr = 1'b0; v2 = 1'b0; op = OP_NONE; addr = '0; frame = '0; cap = '0;
      tmo_init = 16'd1000; tmo_read = 16'd200; tmo_busy = 16'd500;
      want_q.delete();
      fail_count = 0;
    end else begin
      // Compare the delivered result with the oldest prediction
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[27:0]);
        if (want_q.size() == 0) begin
          $error("unexpected result 0x%0h", m_tdata);
          fail_count++;
        end else begin
          ref_r = want_q.pop_front();
          cmp("exchange", ref_r.exchange, got.exchange);
          cmp("tx_byte", ref_r.tx_byte, got.tx_byte);
          cmp("select_low", ref_r.select_low, got.select_low);
          cmp("slow_clock", ref_r.slow_clock, got.slow_clock);
          cmp("read_valid", ref_r.read_valid, got.read_valid);
          cmp("read_byte", ref_r.read_byte, got.read_byte);
          cmp("write_taken", ref_r.write_taken, got.write_taken);
          cmp("done_res", ref_r.done_res, got.done_res);
          cmp("status", ref_r.status, got.status);
          cmp("card_kind", ref_r.card_kind, got.card_kind);
          cmp("pad", 32'd0, m_tdata[31:28]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INIT_TMO: tmo_init = cfg_data;
          REG_READ_TMO: tmo_read = cfg_data;
          REG_BUSY_TMO: tmo_busy = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        predict_step(action_t'(s_tuser), s_tdata[31:0], s_tdata[39:32], s_tdata[47:40]);
    end
    pending = want_q.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the SD SPI host sequencer testbench: clock, reset, card stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import sdh_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // block_number[31:0], rx_byte[39:32], write_byte[47:40]
  logic [2:0]  s_tuser;   // action[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // exchange, tx_byte, select_low, slow_clock, read_valid,
                          // read_byte, write_taken, done_res, status, card_kind
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int          fail_count;
  int          pending;
  phase_t      pred_phase;
  logic [5:0]  pred_cmd;
  logic [9:0]  pred_count;
  logic [1:0]  pred_kind;

  int  burst_left;
  int  gap_max;
  int  tick_pct;
  int  ready_mode;
  bit  hold_req;
  bit  mute;
  int  quiet_cycles;
  int  cyc;

  sd_card_spi_host_engine_core dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sdh_resp_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .pred_phase, .pred_cmd, .pred_count, .pred_kind
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: stalls on its own pattern, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (80) @(negedge clk);
      end
      case (ready_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 99) < 70);
        default: m_tready <= ((cyc % 7) < 5);
      endcase
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 4000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one request, wait for it to be taken, then maybe pause
  task automatic put(input action_t a, input logic [31:0] b, input logic [7:0] r,
                     input logic [7:0] w);
    int gap;
    s_tuser  <= a;
    s_tdata  <= {w, r, b};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic write_cfg(input logic [15:0] v_init, input logic [15:0] v_read,
                           input logic [15:0] v_busy);
    int i;
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? REG_INIT_TMO : (i == 1) ? REG_READ_TMO : REG_BUSY_TMO;
      cfg_data  <= (i == 0) ? v_init : (i == 1) ? v_read : v_busy;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_block();
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) return 32'd0;
    if (p < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Card reply to the byte just exchanged, biased toward the good path
  function automatic logic [7:0] card_reply();
    int p;
    logic [7:0] rnd;
    p   = $urandom_range(0, 99);
    rnd = 8'($urandom);
    case (pred_phase)
      PH_CMD: begin
        if (pred_count < 7) return rnd;
        if (pred_count == 7) mute = ($urandom_range(0, 99) < 6);
        if (mute || p < 25) return 8'hFF;
        p = $urandom_range(0, 99);
        case (pred_cmd)
          6'd0:  return (p < 85) ? 8'h01 : rnd;
          6'd8:  return (p < 70) ? 8'h01 : (p < 85) ? 8'h05 : (rnd & 8'h7F);
          6'd55: return (p < 85) ? 8'h01 : rnd;
          6'd41: return (p < 35) ? 8'h00 : (p < 90) ? 8'h01 : rnd;
          default: return (p < 88) ? 8'h00 : (rnd & 8'h7F);
        endcase
      end
      PH_R7: begin
        if (pred_count == 2) return (p < 90) ? 8'h01 : rnd;
        if (pred_count == 3) return (p < 90) ? 8'hAA : rnd;
        return rnd;
      end
      PH_BUSY_BEFORE, PH_BUSY_AFTER: return (p < 60) ? 8'hFF : rnd;
      PH_TOKEN: return (p < 35) ? 8'hFF : (p < 90) ? 8'hFE : rnd;
      PH_WRESP: return (p < 85) ? {rnd[7:5], 5'h05} : rnd;
      default: return rnd;
    endcase
  endfunction

  task automatic one_item(input bit noisy);
    int p;
    p = $urandom_range(0, 99);
    if (noisy && p < 4) begin
      put(action_t'(3'($urandom)), $urandom, 8'($urandom), 8'($urandom));
    end else if (pred_phase == PH_IDLE) begin
      p = $urandom_range(0, 99);
      if (pred_kind == 2'd0 ? p < 85 : p < 15)
        put(ACT_INIT, pick_block(), 8'($urandom), 8'($urandom));
      else if (p < 57)
        put(ACT_READ, pick_block(), 8'($urandom), 8'($urandom));
      else
        put(ACT_WRITE, pick_block(), 8'($urandom), 8'($urandom));
    end else if (noisy && $urandom_range(0, 99) < tick_pct) begin
      put(ACT_TICK, $urandom, 8'($urandom), 8'($urandom));
    end else begin
      put(ACT_BYTE, $urandom, card_reply(), 8'($urandom));
    end
  endtask

  // Random traffic, then bytes only until the sequencer is back to idle
  task automatic run_phase(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (i == 50 && ready_mode == 1) hold_req = 1'b1;
      one_item(1'b1);
    end
    while (pred_phase != PH_IDLE) one_item(1'b0);
  endtask

  // Stop offering requests and let every result drain
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = ACT_TICK;
    cfg_valid = 1'b0; cfg_index = REG_INIT_TMO; cfg_data = '0;
    hold_req = 1'b0; mute = 1'b0; quiet_cycles = 0;
    burst_left = 0; gap_max = 4; tick_pct = 3; ready_mode = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: ignored items, not-initialized requests, start while busy
    put(ACT_BYTE, 32'd0, 8'h00, 8'h00);
    put(action_t'(3'd5), 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    put(action_t'(3'd6), 32'd0, 8'h00, 8'h00);
    put(action_t'(3'd7), 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    put(ACT_TICK, 32'd0, 8'h00, 8'h00);
    put(ACT_READ, 32'd0, 8'h00, 8'h00);
    put(ACT_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    put(ACT_INIT, 32'd0, 8'h00, 8'h00);
    put(ACT_INIT, 32'd0, 8'h00, 8'h00);
    put(ACT_READ, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    put(ACT_WRITE, 32'd1, 8'h00, 8'h00);

    // Default timeouts, with one long result-side hold-off
    run_phase(100);
    settle();

    // Shortest nonzero timeouts with frequent ticks
    write_cfg(16'd1, 16'd1, 16'd1);
    tick_pct = 15; ready_mode = 2;
    run_phase(100);
    settle();

    // Zero timeouts: waits fail at once
    write_cfg(16'd0, 16'd0, 16'd0);
    tick_pct = 5; ready_mode = 1;
    run_phase(60);
    settle();

    // Longest timeouts, no idling on either side
    write_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF);
    tick_pct = 3; ready_mode = 0; gap_max = 0;
    run_phase(100);
    settle();

    // Small random timeouts
    write_cfg(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)),
              16'($urandom_range(1, 20)));
    tick_pct = 10; ready_mode = 2; gap_max = 4;
    run_phase(60);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/sdh_pkg.sv
rtl/sdh_step.sv
rtl/sd_card_spi_host_engine_core.sv
tb/sdh_checker.sv
tb/tb_top.sv
